### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

### rtl/tgpr_pkg.sv
// ----------------------------------------------------------------------------
// tgpr_pkg
// Types, constants and helpers of the text grid point renderer.
// ----------------------------------------------------------------------------
package tgpr_pkg;

  localparam int unsigned MAX_ROWS   = 64;
  localparam int unsigned MAX_COLS   = 64;
  localparam int unsigned CELL_COUNT = MAX_ROWS * MAX_COLS;
  localparam int unsigned ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int unsigned COL_W      = 6;
  localparam int unsigned ROW_W      = 6;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned DIM_W      = 7;

  localparam logic [CHAR_W-1:0] BLANK_CHAR = CHAR_W'(32);

  typedef enum logic [1:0] {
    CMD_PLACE  = 2'd0,
    CMD_RENDER = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic {
    REG_NUM_ROWS = 1'b0,
    REG_NUM_COLS = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic              placed;
    logic [CHAR_W-1:0] code;
  } cell_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col));
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] max);
    if (v == '0) begin
      clamp_dim = DIM_W'(1);
    end else if (v > max) begin
      clamp_dim = max;
    end else begin
      clamp_dim = v;
    end
  endfunction

endpackage

### rtl/tgpr_cell_ram.sv
// ----------------------------------------------------------------------------
// tgpr_cell_ram
// Grid cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tgpr_cell_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [tgpr_pkg::ADDR_W-1:0] waddr_i,
  input  tgpr_pkg::cell_t            wdata_i,
  input  logic                       re_i,
  input  logic [tgpr_pkg::ADDR_W-1:0] raddr_i,
  output tgpr_pkg::cell_t            rdata_o
);

  tgpr_pkg::cell_t mem [tgpr_pkg::CELL_COUNT];
  tgpr_pkg::cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/text_grid_point_renderer.sv
// ----------------------------------------------------------------------------
// text_grid_point_renderer
// Places characters on a grid of cells and scans rows out, one char a beat.
// ----------------------------------------------------------------------------
// Input stream: tuser carries the command (place, render row, clear), tdata
// carries x, y and the character. Output stream: one beat per column with
// the character (space where empty) and its column; tlast marks the final
// column of the row. Config channel sets num_rows / num_cols (clamped 1..max).
// Place: a cell read, then a conditional write-back; first write wins.
// Render: after acceptance, one beat per cycle for num_cols columns while the
// receiver is ready; each column passes the memory read register and then the
// output register. The cell memory read port sets this rate. Out-of-grid
// places and renders are dropped. Clear: a walk over all 4096 cells, one cell
// per cycle. Reset runs the same walk; no beat is accepted meanwhile, while
// config writes are taken at any time.
// When the receiver stalls, the output register and the memory read register
// hold two columns and the scan pauses; no data is lost.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_grid_point_renderer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // x[5:0], y[11:6], ch[19:12], zero pad
  input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // char_out[7:0], column[13:8], zero pad
  output logic        m_axis_tlast,  // row_last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PLACE,
    ST_RENDER
  } state_e;

  localparam logic [tgpr_pkg::DIM_W-1:0] MaxRowsDim = tgpr_pkg::DIM_W'(tgpr_pkg::MAX_ROWS);
  localparam logic [tgpr_pkg::DIM_W-1:0] MaxColsDim = tgpr_pkg::DIM_W'(tgpr_pkg::MAX_COLS);
  localparam logic [tgpr_pkg::ADDR_W-1:0] LastCell =
    tgpr_pkg::ADDR_W'(tgpr_pkg::CELL_COUNT - 1);

  state_e                          state_q, state_d;
  logic [tgpr_pkg::DIM_W-1:0]      num_rows_q, num_cols_q;
  logic [tgpr_pkg::ADDR_W-1:0]     clear_idx_q, clear_idx_d;
  logic [tgpr_pkg::ADDR_W-1:0]     place_addr_q, place_addr_d;
  logic [tgpr_pkg::CHAR_W-1:0]     place_ch_q, place_ch_d;
  logic [tgpr_pkg::ROW_W-1:0]      row_q, row_d;
  logic [tgpr_pkg::DIM_W-1:0]      issue_col_q, issue_col_d;
  logic                            pend_q, pend_d;
  logic [tgpr_pkg::COL_W-1:0]      pend_col_q, pend_col_d;
  logic                            out_valid_q, out_valid_d;
  logic [tgpr_pkg::CHAR_W-1:0]     out_char_q, out_char_d;
  logic [tgpr_pkg::COL_W-1:0]      out_col_q, out_col_d;
  logic                            out_last_q, out_last_d;

  logic                            in_fire, load, issue, place_ok, render_ok;
  tgpr_pkg::cmd_e                  cmd;
  logic [tgpr_pkg::COL_W-1:0]      in_x;
  logic [tgpr_pkg::ROW_W-1:0]      in_y;
  logic [tgpr_pkg::CHAR_W-1:0]     in_ch;

  logic                            ram_we, ram_re;
  logic [tgpr_pkg::ADDR_W-1:0]     ram_waddr, ram_raddr;
  tgpr_pkg::cell_t                 ram_wdata, ram_rdata;

  assign cmd   = tgpr_pkg::cmd_e'(s_axis_tuser);
  assign in_x  = s_axis_tdata[5:0];
  assign in_y  = s_axis_tdata[11:6];
  assign in_ch = s_axis_tdata[19:12];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign place_ok      = ({1'b0, in_x} < num_cols_q) && ({1'b0, in_y} < num_rows_q);
  assign render_ok     = ({1'b0, in_y} < num_rows_q);

  assign load  = pend_q && (!out_valid_q || m_axis_tready);
  assign issue = (state_q == ST_RENDER) && (issue_col_q < num_cols_q) && (!pend_q || load);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = tgpr_pkg::cell_addr(in_y, in_x);
    ram_we    = 1'b0;
    ram_waddr = clear_idx_q;
    ram_wdata = '0;
    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        ram_re = in_fire && (cmd == tgpr_pkg::CMD_PLACE) && place_ok;
      end
      ST_PLACE: begin
        ram_we    = !ram_rdata.placed;
        ram_waddr = place_addr_q;
        ram_wdata = '{placed: 1'b1, code: place_ch_q};
      end
      ST_RENDER: begin
        ram_re    = issue;
        ram_raddr = tgpr_pkg::cell_addr(row_q, issue_col_q[tgpr_pkg::COL_W-1:0]);
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  tgpr_cell_ram u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    clear_idx_d  = clear_idx_q;
    place_addr_d = place_addr_q;
    place_ch_d   = place_ch_q;
    row_d        = row_q;
    issue_col_d  = issue_col_q;
    pend_d       = pend_q;
    pend_col_d   = pend_col_q;
    out_valid_d  = out_valid_q;
    out_char_d   = out_char_q;
    out_col_d    = out_col_q;
    out_last_d   = out_last_q;

    case (state_q)
      ST_CLEAR: begin
        clear_idx_d = clear_idx_q + tgpr_pkg::ADDR_W'(1);
        if (clear_idx_q == LastCell) begin
          clear_idx_d = '0;
          state_d     = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (cmd)
            tgpr_pkg::CMD_PLACE: begin
              if (place_ok) begin
                place_addr_d = tgpr_pkg::cell_addr(in_y, in_x);
                place_ch_d   = in_ch;
                state_d      = ST_PLACE;
              end
            end
            tgpr_pkg::CMD_RENDER: begin
              if (render_ok) begin
                row_d       = in_y;
                issue_col_d = '0;
                state_d     = ST_RENDER;
              end
            end
            tgpr_pkg::CMD_CLEAR: begin
              clear_idx_d = '0;
              state_d     = ST_CLEAR;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_PLACE: begin
        state_d = ST_IDLE;
      end
      ST_RENDER: begin
        if ((issue_col_q == num_cols_q) && !pend_q) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // advance the scan: memory read register feeds the output register
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      out_char_d  = ram_rdata.placed ? ram_rdata.code : tgpr_pkg::BLANK_CHAR;
      out_col_d   = pend_col_q;
      out_last_d  = (tgpr_pkg::DIM_W'(pend_col_q) + tgpr_pkg::DIM_W'(1)) == num_cols_q;
      pend_d      = 1'b0;
    end
    if (issue) begin
      pend_d      = 1'b1;
      pend_col_d  = issue_col_q[tgpr_pkg::COL_W-1:0];
      issue_col_d = issue_col_q + tgpr_pkg::DIM_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clear_idx_q  <= '0;
      issue_col_q  <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      place_addr_q <= '0;
      place_ch_q   <= '0;
      row_q        <= '0;
      pend_col_q   <= '0;
      out_char_q   <= '0;
      out_col_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      clear_idx_q  <= clear_idx_d;
      issue_col_q  <= issue_col_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
      place_addr_q <= place_addr_d;
      place_ch_q   <= place_ch_d;
      row_q        <= row_d;
      pend_col_q   <= pend_col_d;
      out_char_q   <= out_char_d;
      out_col_q    <= out_col_d;
      out_last_q   <= out_last_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= MaxRowsDim;
      num_cols_q <= MaxColsDim;
    end else if (cfg_valid_i) begin
      case (tgpr_pkg::reg_idx_e'(cfg_index_i))
        tgpr_pkg::REG_NUM_ROWS: num_rows_q <= tgpr_pkg::clamp_dim(cfg_data_i, MaxRowsDim);
        tgpr_pkg::REG_NUM_COLS: num_cols_q <= tgpr_pkg::clamp_dim(cfg_data_i, MaxColsDim);
        default: num_rows_q <= num_rows_q;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_col_q, out_char_q};
  assign m_axis_tlast  = out_last_q;

  `ASSERT_NEVER(a_no_accept_in_clear, (state_q == ST_CLEAR) && s_axis_tready, "accept during clear walk")
  `ASSERT_NEVER(a_no_write_in_render, ram_we && (state_q == ST_RENDER), "cell write during scan")
  `ASSERT_HOLDS(a_scan_in_bounds, (state_q == ST_RENDER) |-> issue_col_q <= num_cols_q, "scan past row end")
  `ASSERT_HOLDS(a_pend_only_render, pend_q |-> (state_q == ST_RENDER), "read data pending outside scan")
  `ASSERT_HOLDS(a_place_follows_read, (state_q == ST_PLACE) |-> $past(ram_re), "place without cell read")

endmodule

### tb/text_grid_point_renderer_checker.sv
// ----------------------------------------------------------------------------
// text_grid_point_renderer_checker
// Watches the place/render stream, the config channel and the character
// stream. Keeps a shadow grid and the current dimensions, predicts the
// characters of every rendered row and compares each output beat, field by
// field, against the oldest predicted column.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_grid_point_renderer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [23:0] s_tdata_i,   // x[5:0], y[11:6], ch[19:12], zero pad
  input  logic [1:0]  s_tuser_i,   // cmd[1:0]
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,   // char_out[7:0], column[13:8], zero pad
  input  logic        m_tlast_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [tgpr_pkg::CHAR_W-1:0] code;
    logic [tgpr_pkg::COL_W-1:0]  column;
    logic                        last;
  } col_beat_t;

  tgpr_pkg::cell_t            shadow_cells [tgpr_pkg::CELL_COUNT];
  col_beat_t                  row_columns [$];
  logic [tgpr_pkg::DIM_W-1:0] grid_rows;
  logic [tgpr_pkg::DIM_W-1:0] grid_cols;
  int                         errors = 0;

  function automatic logic [tgpr_pkg::DIM_W-1:0] fit_dim(input logic [tgpr_pkg::DIM_W-1:0] v,
                                                         input int unsigned lim);
    if (v == '0) return tgpr_pkg::DIM_W'(1);
    if (v > lim) return tgpr_pkg::DIM_W'(lim);
    return v;
  endfunction

  task automatic wipe_grid();
    for (int i = 0; i < tgpr_pkg::CELL_COUNT; i++) shadow_cells[i] = '0;
  endtask

  task automatic scan_row(input logic [tgpr_pkg::ROW_W-1:0] row);
    tgpr_pkg::cell_t c;
    col_beat_t       b;
    for (int col = 0; col < int'(grid_cols); col++) begin
      c        = shadow_cells[{row, tgpr_pkg::COL_W'(col)}];
      b.code   = c.placed ? c.code : tgpr_pkg::BLANK_CHAR;
      b.column = tgpr_pkg::COL_W'(col);
      b.last   = (col + 1 == int'(grid_cols));
      row_columns.push_back(b);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    col_beat_t                   want;
    logic [tgpr_pkg::COL_W-1:0]  px;
    logic [tgpr_pkg::ROW_W-1:0]  py;
    logic [tgpr_pkg::CHAR_W-1:0] pch;
    if (!rst_ni) begin
      wipe_grid();
      grid_rows = tgpr_pkg::DIM_W'(tgpr_pkg::MAX_ROWS);
      grid_cols = tgpr_pkg::DIM_W'(tgpr_pkg::MAX_COLS);
      row_columns.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (row_columns.size() == 0) begin
          $display("%0t: beat with nothing expected: char %0d column %0d last %0b",
                   $time, m_tdata_i[7:0], m_tdata_i[13:8], m_tlast_i);
          errors++;
        end else begin
          want = row_columns.pop_front();
          if (m_tdata_i[7:0] !== want.code) begin
            $display("%0t: char_out expected %0d actual %0d",
                     $time, want.code, m_tdata_i[7:0]);
            errors++;
          end
          if (m_tdata_i[13:8] !== want.column) begin
            $display("%0t: column expected %0d actual %0d",
                     $time, want.column, m_tdata_i[13:8]);
            errors++;
          end
          if (m_tlast_i !== want.last) begin
            $display("%0t: row_last expected %0b actual %0b",
                     $time, want.last, m_tlast_i);
            errors++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == tgpr_pkg::REG_NUM_ROWS) begin
          grid_rows = fit_dim(cfg_data_i, tgpr_pkg::MAX_ROWS);
        end else begin
          grid_cols = fit_dim(cfg_data_i, tgpr_pkg::MAX_COLS);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        px  = s_tdata_i[5:0];
        py  = s_tdata_i[11:6];
        pch = s_tdata_i[19:12];
        case (s_tuser_i)
          tgpr_pkg::CMD_PLACE: begin
            if (px < grid_cols && py < grid_rows && !shadow_cells[{py, px}].placed) begin
              shadow_cells[{py, px}] = '{placed: 1'b1, code: pch};
            end
          end
          tgpr_pkg::CMD_RENDER: begin
            if (py < grid_rows) scan_row(py);
          end
          tgpr_pkg::CMD_CLEAR: wipe_grid();
          default: ;
        endcase
      end
    end
    fail_count_o <= errors;
    pending_o    <= row_columns.size();
  end

endmodule

### tb/tb_text_grid_point_renderer.sv
// ----------------------------------------------------------------------------
// tb_text_grid_point_renderer
// Drives place, render, clear and unused commands into the renderer under
// several grid sizes, including out-of-range register values, with random
// gaps on the input and random stalls on the output, one long output stall
// and one drain pause. The checker predicts and compares; this module makes
// stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_text_grid_point_renderer;

  localparam logic [1:0] CMD_UNUSED    = 2'd3;
  localparam int         SETTLE_CYCLES = tgpr_pkg::CELL_COUNT + 64;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         PHASES        = 8;
  localparam int         PHASE_OPS     = 48;

  typedef struct packed {
    logic [1:0]                  cmd;
    logic [tgpr_pkg::COL_W-1:0]  x;
    logic [tgpr_pkg::ROW_W-1:0]  y;
    logic [tgpr_pkg::CHAR_W-1:0] ch;
  } grid_op_t;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic        cfg_index     = 1'b0;
  logic [6:0]  cfg_data      = '0;

  grid_op_t op_fifo [$];
  bit       quiet    = 1'b0;
  bit       hold_req = 1'b0;
  int       fail_count;
  int       pending;
  int       cur_rows = tgpr_pkg::MAX_ROWS;
  int       cur_cols = tgpr_pkg::MAX_COLS;

  always #5 clk = ~clk;

  text_grid_point_renderer dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  text_grid_point_renderer_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tlast_i    (m_axis_tlast),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin : source
    forever begin
      @(posedge clk);
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (s_axis_tvalid) op_fifo.delete(0);
        if (op_fifo.size() != 0 && (quiet || $urandom_range(99) >= 7)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= op_fifo[0].cmd;
          s_axis_tdata  <= {4'b0, op_fifo[0].ch, op_fifo[0].y, op_fifo[0].x};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  initial begin : sink
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_axis_tready <= quiet || ($urandom_range(99) >= 7);
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic push_op(input logic [1:0] cmd, input int x, input int y, input int ch);
    grid_op_t op;
    op.cmd = cmd;
    op.x   = tgpr_pkg::COL_W'(x);
    op.y   = tgpr_pkg::ROW_W'(y);
    op.ch  = tgpr_pkg::CHAR_W'(ch);
    op_fifo.push_back(op);
    while (op_fifo.size() > 3) @(posedge clk);
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (op_fifo.size() != 0 || s_axis_tvalid || pending != 0);
  endtask

  task automatic reconfigure(input logic [6:0] rows, input logic [6:0] cols);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= tgpr_pkg::REG_NUM_ROWS;
    cfg_data  <= rows;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= tgpr_pkg::REG_NUM_COLS;
    cfg_data  <= cols;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_rows = (rows == 0) ? 1 : (rows > tgpr_pkg::MAX_ROWS) ? tgpr_pkg::MAX_ROWS : rows;
    cur_cols = (cols == 0) ? 1 : (cols > tgpr_pkg::MAX_COLS) ? tgpr_pkg::MAX_COLS : cols;
  endtask

  task automatic random_op();
    int roll;
    int x;
    int y;
    roll = $urandom_range(199);
    x = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(cur_cols - 1);
    y = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(cur_rows - 1);
    if (roll < 3) push_op(tgpr_pkg::CMD_CLEAR, x, y, $urandom_range(255));
    else if (roll < 7) push_op(CMD_UNUSED, x, y, $urandom_range(255));
    else if (roll < 140) push_op(tgpr_pkg::CMD_PLACE, x, y, $urandom_range(255));
    else push_op(tgpr_pkg::CMD_RENDER, x, y, $urandom_range(255));
  endtask

  initial begin : stimulus
    logic [6:0] rows;
    logic [6:0] cols;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    push_op(tgpr_pkg::CMD_PLACE, 0, 0, 8'h41);
    push_op(tgpr_pkg::CMD_PLACE, 63, 63, 8'hFF);
    push_op(tgpr_pkg::CMD_PLACE, 63, 0, 8'h00);
    push_op(tgpr_pkg::CMD_PLACE, 0, 63, 8'h80);
    push_op(tgpr_pkg::CMD_PLACE, 42, 21, 8'h55);
    push_op(tgpr_pkg::CMD_PLACE, 21, 42, 8'hAA);
    push_op(tgpr_pkg::CMD_PLACE, 0, 0, 8'h5A);
    push_op(CMD_UNUSED, 63, 63, 8'hFF);
    push_op(tgpr_pkg::CMD_RENDER, 0, 0, 0);
    push_op(tgpr_pkg::CMD_RENDER, 0, 63, 0);
    push_op(tgpr_pkg::CMD_RENDER, 0, 21, 0);
    reconfigure(7'd0, 7'd0);
    push_op(tgpr_pkg::CMD_PLACE, 1, 0, 8'h31);
    push_op(tgpr_pkg::CMD_PLACE, 0, 1, 8'h32);
    push_op(tgpr_pkg::CMD_RENDER, 0, 1, 0);
    push_op(tgpr_pkg::CMD_RENDER, 0, 0, 0);
    reconfigure(7'd127, 7'd3);
    push_op(tgpr_pkg::CMD_RENDER, 0, 63, 0);
    push_op(tgpr_pkg::CMD_PLACE, 3, 5, 8'h33);
    push_op(tgpr_pkg::CMD_RENDER, 0, 5, 0);
    reconfigure(7'd64, 7'd64);
    push_op(tgpr_pkg::CMD_RENDER, 0, 63, 0);
    push_op(tgpr_pkg::CMD_CLEAR, 0, 0, 0);
    push_op(tgpr_pkg::CMD_RENDER, 0, 63, 0);
    push_op(tgpr_pkg::CMD_PLACE, 0, 0, 8'h42);
    push_op(tgpr_pkg::CMD_RENDER, 0, 0, 0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin rows = 7'd64;  cols = 7'd64;  end
        1: begin rows = 7'd8;   cols = 7'd8;   end
        2: begin rows = 7'd1;   cols = 7'd64;  end
        3: begin rows = 7'd64;  cols = 7'd1;   end
        4: begin rows = 7'd0;   cols = 7'd0;   end
        5: begin rows = 7'($urandom_range(127)); cols = 7'($urandom_range(127)); end
        6: begin rows = 7'd65;  cols = 7'd127; end
        default: begin rows = 7'd64; cols = 7'd64; end
      endcase
      reconfigure(rows, cols);
      quiet <= (p == 0);
      if (p == PHASES - 1) begin
        hold_req <= 1'b1;
        repeat (8) push_op(tgpr_pkg::CMD_RENDER, 0, $urandom_range(cur_rows - 1), 0);
      end
      for (int i = 0; i < PHASE_OPS; i++) begin
        if (p == 1 && i == PHASE_OPS / 2) wait_idle();
        random_op();
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### text_grid_point_renderer.f
+incdir+rtl
rtl/tgpr_pkg.sv
rtl/tgpr_cell_ram.sv
rtl/text_grid_point_renderer.sv
tb/text_grid_point_renderer_checker.sv
tb/tb_text_grid_point_renderer.sv
